>>> rtl/core/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// shared types and constants for the key-value table
// ----------------------------------------------------------------------------
package kvt_pkg;

  // fixed port widths of the request and result words
  localparam int unsigned KVT_KEY_W   = 32;
  localparam int unsigned KVT_VALUE_W = 32;

  // default configuration
  localparam int unsigned KVT_ENTRIES    = 16;
  localparam int unsigned KVT_KEY_BITS   = 32;
  localparam int unsigned KVT_VALUE_BITS = 32;

  typedef enum logic [1:0] {
    REQ_DEFINE = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_GET    = 2'd2,
    REQ_DELETE = 2'd3
  } kvt_req_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, restart the scan
    logic scan_rd;  // read the entry at the scan pointer
    logic exec;     // apply the update, fetch the value
  } kvt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // scan pointer is on the last entry
  } kvt_stat_t;

endpackage

>>> rtl/core/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table
// fixed-size key-value store with a linear search over its entries
// ----------------------------------------------------------------------------
// One request word is taken when start is high while busy is low. The block
// then walks every entry once with a single key comparator, one entry a
// cycle. After the last entry is read, the sequencer passes through a flush
// state that finishes the last compare, an update state that writes the
// table and a response state that presents the result. busy stays high
// through the response state, so the block takes no new request before it is
// through with the last one; the next request is taken in the idle state that
// follows. The result word sits on found_o, read_value_o and status_o for the
// single cycle in which done_o is high; there is no way to hold it, so the
// receiver must take it then. Occupancy marks are cleared by reset; the key
// and value stores are not, and need no clearing as an entry is only used
// once its mark is set.
//
// requests
//   define  overwrite the value of a present key, else claim the lowest free
//           entry; with no free entry nothing changes and status_o is set
//   query   report presence only
//   get     return the stored value of a present key, else zero
//   delete  free the entry that holds the key
// found_o always tells whether the key was present before the request.
// ----------------------------------------------------------------------------
module key_value_table
  import kvt_pkg::*;
#(
  parameter int unsigned ENTRIES    = KVT_ENTRIES,
  parameter int unsigned KEY_BITS   = KVT_KEY_BITS,
  parameter int unsigned VALUE_BITS = KVT_VALUE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request word
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type_i,
  input  logic [KVT_KEY_W-1:0]   key_i,
  input  logic [KVT_VALUE_W-1:0] value_i,
  // result word, valid for one cycle
  output logic                   done_o,
  output logic                   found_o,
  output logic [KVT_VALUE_W-1:0] read_value_o,
  output logic                   status_o
);

  kvt_cmd_t  cmd;
  kvt_stat_t stat;

  // sequencer: idle, scan, flush the compare stage, update, respond
  kvt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // stores, comparator and result registers
  kvt_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

endmodule

>>> rtl/core/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// request sequencer: accept, scan, flush, update, respond
// ----------------------------------------------------------------------------
module kvt_ctrl
  import kvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      done_o,
  output kvt_cmd_t  cmd_o,
  input  kvt_stat_t stat_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_FLUSH = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_RESP  = 5'b10000
  } kvt_state_e;

  kvt_state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.scan_rd = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_FLUSH;
        end
      end
      // last compare lands here
      ST_FLUSH: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

endmodule

>>> rtl/core/kvt_datapath.sv
// ----------------------------------------------------------------------------
// kvt_datapath
// key and value stores, scan comparator and result registers
// ----------------------------------------------------------------------------
module kvt_datapath
  import kvt_pkg::*;
#(
  parameter int unsigned ENTRIES    = KVT_ENTRIES,
  parameter int unsigned KEY_BITS   = KVT_KEY_BITS,
  parameter int unsigned VALUE_BITS = KVT_VALUE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kvt_cmd_t               cmd_i,
  output kvt_stat_t              stat_o,
  input  logic [1:0]             req_type_i,
  input  logic [KVT_KEY_W-1:0]   key_i,
  input  logic [KVT_VALUE_W-1:0] value_i,
  output logic                   found_o,
  output logic [KVT_VALUE_W-1:0] read_value_o,
  output logic                   status_o
);

  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KEY_CUT = (KEY_BITS < KVT_KEY_W) ? KEY_BITS : KVT_KEY_W;
  localparam int unsigned VAL_CUT = (VALUE_BITS < KVT_VALUE_W) ? VALUE_BITS : KVT_VALUE_W;

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [ENTRIES-1:0]    valid_q;

  kvt_req_e              req_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [KEY_BITS-1:0]   key_ext;
  logic [VALUE_BITS-1:0] value_ext;

  logic [IDX_W-1:0]      cnt_q;
  logic                  cmp_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [KEY_BITS-1:0]   key_rd_q;
  logic                  vld_rd_q;

  logic                  hit_vld_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic                  free_vld_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic [IDX_W-1:0]      wr_idx;

  logic                  found_q;
  logic                  status_q;
  logic                  rd_sel_q;
  logic [VALUE_BITS-1:0] val_rd_q;

  // fit the port words to the stored widths
  always_comb begin
    key_ext                  = '0;
    key_ext[KEY_CUT-1:0]     = key_i[KEY_CUT-1:0];
    value_ext                = '0;
    value_ext[VAL_CUT-1:0]   = value_i[VAL_CUT-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= kvt_req_e'(req_type_i);
      key_q   <= key_ext;
      value_q <= value_ext;
    end
  end

  assign stat_o.scan_last = (cnt_q == IDX_W'(ENTRIES - 1));

  // scan pointer and compare pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      hit_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        cnt_q      <= '0;
        hit_vld_q  <= 1'b0;
        free_vld_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (cmp_vld_q && vld_rd_q && (key_rd_q == key_q)) begin
          hit_vld_q <= 1'b1;
        end
        if (cmp_vld_q && !vld_rd_q && !free_vld_q) begin
          free_vld_q <= 1'b1;
        end
      end
    end
  end

  // registered read of the scanned entry and match bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      key_rd_q <= key_mem[cnt_q];
      vld_rd_q <= valid_q[cnt_q];
      rd_idx_q <= cnt_q;
    end
    if (cmp_vld_q && vld_rd_q && (key_rd_q == key_q)) begin
      hit_idx_q <= rd_idx_q;
    end
    if (cmp_vld_q && !vld_rd_q && !free_vld_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  assign wr_idx = hit_vld_q ? hit_idx_q : free_idx_q;

  // key and value stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (req_q == REQ_DEFINE)) begin
      if (hit_vld_q) begin
        val_mem[wr_idx] <= value_q;
      end else if (free_vld_q) begin
        key_mem[wr_idx] <= key_q;
        val_mem[wr_idx] <= value_q;
      end
    end
    if (cmd_i.exec && (req_q == REQ_GET)) begin
      val_rd_q <= val_mem[hit_idx_q];
    end
  end

  // occupancy marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.exec) begin
      if ((req_q == REQ_DEFINE) && !hit_vld_q && free_vld_q) begin
        valid_q[wr_idx] <= 1'b1;
      end else if ((req_q == REQ_DELETE) && hit_vld_q) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      found_q  <= hit_vld_q;
      status_q <= (req_q == REQ_DEFINE) && !hit_vld_q && !free_vld_q;
      rd_sel_q <= (req_q == REQ_GET) && hit_vld_q;
    end
  end

  always_comb begin
    read_value_o = '0;
    if (rd_sel_q) begin
      read_value_o[VAL_CUT-1:0] = val_rd_q[VAL_CUT-1:0];
    end
  end

  assign found_o  = found_q;
  assign status_o = status_q;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the key-value table: a directed table of request
// words (empty table, extreme keys and values, overwrite, full table, delete
// and reuse of a freed entry) followed by random request words drawn mostly
// from small key pools, each result word checked against a result typed in
// by hand or against a software copy of the table
// ----------------------------------------------------------------------------
module testbench;
  import kvt_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned TABLE_DEPTH  = KVT_ENTRIES;
  // drain for as long as two back-to-back words take
  localparam int unsigned DRAIN_CYCLES = 2 * (KVT_ENTRIES + 4);
  // about 730 words at their slowest pace, taken many times over
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned N_PHASES     = 4;
  localparam int unsigned PHASE_WORDS  = 175;
  localparam int unsigned MAX_REPORTS  = 10;

  // one result word as the block presents it
  typedef struct packed {
    logic                   found;
    logic [KVT_VALUE_W-1:0] read_value;
    logic                   status;
  } result_word_t;

  // one row of the directed table; reps repeats the row with key and value
  // stepping by one, pinned rows carry a result typed in by hand
  typedef struct {
    kvt_req_e               req;
    logic [KVT_KEY_W-1:0]   key;
    logic [KVT_VALUE_W-1:0] value;
    int unsigned            reps;
    bit                     pinned;
    result_word_t           res;
  } request_row_t;

  localparam int unsigned N_ROWS = 17;

  // ---------------------------------------------------------------------------
  // directed requests
  // ---------------------------------------------------------------------------
  request_row_t request_rows [N_ROWS] = '{
    // empty table after reset: nothing is present
    '{REQ_QUERY,  32'h0000_0000, 32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 1'b0}},
    // get on a missing key gives zero
    '{REQ_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,  1'b1, '{1'b0, 32'h0, 1'b0}},
    // delete of a missing key changes nothing
    '{REQ_DELETE, 32'hAAAA_AAAA, 32'h5555_5555, 1,  1'b1, '{1'b0, 32'h0, 1'b0}},
    // extreme keys against extreme values
    '{REQ_DEFINE, 32'h0000_0000, 32'hFFFF_FFFF, 1,  1'b1, '{1'b0, 32'h0, 1'b0}},
    '{REQ_GET,    32'h0000_0000, 32'h0000_0000, 1,  1'b1,
      '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{REQ_DEFINE, 32'hFFFF_FFFF, 32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 1'b0}},
    '{REQ_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,  1'b1, '{1'b1, 32'h0, 1'b0}},
    // overwrite of a present key
    '{REQ_DEFINE, 32'h0000_0000, 32'h5A5A_0F0F, 1,  1'b1, '{1'b1, 32'h0, 1'b0}},
    // fill the remaining fourteen entries
    '{REQ_DEFINE, 32'h0000_0001, 32'hA5A5_F0F0, 14, 1'b1, '{1'b0, 32'h0, 1'b0}},
    // new key on a full table is dropped
    '{REQ_DEFINE, 32'h8000_0000, 32'h0000_0001, 1,  1'b1, '{1'b0, 32'h0, 1'b1}},
    '{REQ_QUERY,  32'h0000_000E, 32'h0000_0000, 1,  1'b1, '{1'b1, 32'h0, 1'b0}},
    // a present key is still overwritten when the table is full
    '{REQ_DEFINE, 32'h0000_000E, 32'hDEAD_BEEF, 1,  1'b1, '{1'b1, 32'h0, 1'b0}},
    '{REQ_GET,    32'h0000_000E, 32'h0000_0000, 1,  1'b1,
      '{1'b1, 32'hDEAD_BEEF, 1'b0}},
    // free one entry, then the new key fits
    '{REQ_DELETE, 32'h0000_0007, 32'h0000_0000, 1,  1'b1, '{1'b1, 32'h0, 1'b0}},
    '{REQ_DEFINE, 32'h8000_0000, 32'h1234_5678, 1,  1'b1, '{1'b0, 32'h0, 1'b0}},
    '{REQ_GET,    32'h8000_0000, 32'h0000_0000, 1,  1'b0, '{1'b0, 32'h0, 1'b0}},
    '{REQ_DELETE, 32'h8000_0000, 32'h0000_0000, 1,  1'b0, '{1'b0, 32'h0, 1'b0}}
  };

  // random phases: key pool size and share of define requests
  int unsigned pool_sizes  [N_PHASES] = '{6, 20, 40, 17};
  int unsigned define_pcts [N_PHASES] = '{45, 60, 40, 50};

  // ---------------------------------------------------------------------------
  // dut signals
  // ---------------------------------------------------------------------------
  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             req_type_i;
  logic [KVT_KEY_W-1:0]   key_i;
  logic [KVT_VALUE_W-1:0] value_i;
  logic                   done_o;
  logic                   found_o;
  logic [KVT_VALUE_W-1:0] read_value_o;
  logic                   status_o;

  key_value_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

  // ---------------------------------------------------------------------------
  // software copy of the table
  // ---------------------------------------------------------------------------
  logic [KVT_KEY_W-1:0]   shadow_keys   [TABLE_DEPTH];
  logic [KVT_VALUE_W-1:0] shadow_values [TABLE_DEPTH];
  bit                     shadow_used   [TABLE_DEPTH];

  // results still owed by the block, oldest first
  result_word_t owed_results [$];

  // pinned result travelling with the word on the request ports
  bit           word_pinned;
  result_word_t word_pin_res;

  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned found_count;
  int unsigned dropped_count;
  int unsigned cycle_count;

  result_word_t predicted;
  result_word_t observed;
  result_word_t wanted;

  // apply one request to the software table and return its result word
  function automatic result_word_t apply_request(kvt_req_e req,
                                                 logic [KVT_KEY_W-1:0] key,
                                                 logic [KVT_VALUE_W-1:0] value);
    result_word_t res;
    int hit;
    int free_slot;
    res  = '0;
    hit  = -1;
    free_slot = -1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (shadow_used[i] && shadow_keys[i] == key) hit = i;
      if (!shadow_used[i]) free_slot = i;
    end
    res.found = (hit >= 0);
    case (req)
      REQ_DEFINE: begin
        if (hit >= 0) begin
          shadow_values[hit] = value;
        end else if (free_slot >= 0) begin
          shadow_keys[free_slot]   = key;
          shadow_values[free_slot] = value;
          shadow_used[free_slot]   = 1'b1;
        end else begin
          // no free entry: dropped
          res.status = 1'b1;
        end
      end
      REQ_GET: begin
        if (hit >= 0) res.read_value = shadow_values[hit];
      end
      REQ_DELETE: begin
        if (hit >= 0) shadow_used[hit] = 1'b0;
      end
      default: begin
        // query only reports presence
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, owed_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: results are checked first, then a word taken on this edge is
  // predicted, so a result and a new word on the same edge keep their order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      observed = '{found_o, read_value_o, status_o};
      if (owed_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result word: found %b value %h status %b",
                   observed.found, observed.read_value, observed.status);
        mismatches++;
      end else begin
        wanted = owed_results.pop_front();
        words_checked++;
        if (observed.found)  found_count++;
        if (observed.status) dropped_count++;
        if (observed.found !== wanted.found ||
            observed.read_value !== wanted.read_value ||
            observed.status !== wanted.status) begin
          if (mismatches < MAX_REPORTS)
            $display("result %0d: expected found %b value %h status %b, got %b %h %b",
                     words_checked, wanted.found, wanted.read_value, wanted.status,
                     observed.found, observed.read_value, observed.status);
          mismatches++;
        end
      end
    end
    if (rst_ni === 1'b1 && start === 1'b1 && busy === 1'b0) begin
      predicted = apply_request(kvt_req_e'(req_type_i), key_i, value_i);
      if (word_pinned) owed_results = {owed_results, word_pin_res};
      else owed_results = {owed_results, predicted};
    end
  end

  // ---------------------------------------------------------------------------
  // driver: called at a falling edge, returns at the falling edge after the
  // word was taken; once the block is free, a random gap of idle cycles goes
  // ahead of every word
  // ---------------------------------------------------------------------------
  task automatic send_request(input kvt_req_e req, input logic [KVT_KEY_W-1:0] key,
                              input logic [KVT_VALUE_W-1:0] value, input bit pinned,
                              input result_word_t pin_res);
    int unsigned gap;
    gap = $urandom_range(0, 4);
    start <= 1'b0;
    while (busy !== 1'b0) @(negedge clk_i);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start        <= 1'b1;
    req_type_i   <= req;
    key_i        <= key;
    value_i      <= value;
    word_pinned  <= pinned;
    word_pin_res <= pin_res;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
  endtask

  logic [KVT_KEY_W-1:0] key_pool [64];

  initial begin
    logic [KVT_KEY_W-1:0] pick;
    kvt_req_e             op;
    int unsigned          roll;
    int unsigned          size;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = REQ_DEFINE;
    key_i        = '0;
    value_i      = '0;
    word_pinned  = 1'b0;
    word_pin_res = '0;
    mismatches    = 0;
    words_checked = 0;
    found_count   = 0;
    dropped_count = 0;
    cycle_count   = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) shadow_used[i] = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (request_rows[r]) begin
      for (int unsigned i = 0; i < request_rows[r].reps; i++)
        send_request(request_rows[r].req, request_rows[r].key + i,
                     request_rows[r].value + i, request_rows[r].pinned,
                     request_rows[r].res);
    end

    // random phases: mostly keys from a small pool so that hits, overwrites
    // and a full table happen often; some keys one bit off a pool key and
    // some fully random
    for (int ph = 0; ph < N_PHASES; ph++) begin
      size = pool_sizes[ph];
      for (int j = 0; j < size; j++) key_pool[j] = $urandom;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) pick = key_pool[$urandom_range(0, size - 1)];
        else if (roll < 90)
          pick = key_pool[$urandom_range(0, size - 1)] ^ (32'h1 << $urandom_range(0, 31));
        else pick = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < define_pcts[ph]) begin
          op = REQ_DEFINE;
        end else begin
          case ($urandom_range(0, 2))
            0:       op = REQ_QUERY;
            1:       op = REQ_GET;
            default: op = REQ_DELETE;
          endcase
        end
        send_request(op, pick, $urandom, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d result words over %0d key pools: %0d with the key present,",
             words_checked, N_PHASES, found_count);
    $display("%0d defines dropped on a full table, %0d mismatches",
             dropped_count, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/kvt_pkg.sv
rtl/core/kvt_ctrl.sv
rtl/core/kvt_datapath.sv
rtl/core/key_value_table.sv
tb/sv/testbench.sv
